// ===== sv/sliding_window_event_rate_meter_defines.svh =====
// Assertion macros for the sliding window event rate meter.
// No dependencies; included by files that carry concurrent checks.
`ifndef SLIDING_WINDOW_EVENT_RATE_METER_DEFINES_SVH
`define SLIDING_WINDOW_EVENT_RATE_METER_DEFINES_SVH
`ifndef SYNTHESIS
// clocked check, held off while reset is active
`define SWERM_ASSERT(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
        else $error("check failed");
// clocked check that also holds during reset
`define SWERM_ASSERT_ALWAYS(lbl, clk_s, prop) \
    lbl: assert property (@(posedge clk_s) prop) \
        else $error("check failed");
`else
`define SWERM_ASSERT(lbl, clk_s, rstn_s, prop)
`define SWERM_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif
`endif

// ===== sv/swerm_pkg.sv =====
// Shared widths, limits and control structs for the event rate meter.
// No dependencies.
package swerm_pkg;

    localparam int CNT_W  = 8;
    localparam int WIN_W  = 14;
    localparam int TOT_W  = 32;
    localparam int ACT_W  = 32;
    localparam int FRAC_W = 8;
    localparam int AVG_W  = 40;

    localparam logic [TOT_W-1:0] TOT_MAX = '1;
    localparam logic [ACT_W-1:0] ACT_MAX = '1;
    localparam logic [ACT_W-1:0] ACT_ONE = ACT_W'(1);

    // control fanned out to every slot cell
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== sv/swerm_tick_if.sv =====
// Input channel: one tick request with its event count and clear flag.
// Depends on swerm_pkg.
interface swerm_tick_if;
    logic                       valid;
    logic                       ready;
    logic [swerm_pkg::CNT_W-1:0] event_count;
    logic                       clear;

    modport source (output valid, output event_count, output clear, input ready);
    modport sink   (input valid, input event_count, input clear, output ready);
endinterface

// ===== sv/swerm_result_if.sv =====
// Output channel: one result request per tick.
// Depends on swerm_pkg.
interface swerm_result_if;
    logic                        valid;
    logic                        ready;
    logic [swerm_pkg::TOT_W-1:0] total_events;
    logic [swerm_pkg::WIN_W-1:0] window_rate;
    logic [swerm_pkg::WIN_W-1:0] peak_rate;
    logic [swerm_pkg::AVG_W-1:0] average_rate;

    modport source (output valid, output total_events, output window_rate,
                    output peak_rate, output average_rate, input ready);
    modport sink   (input valid, input total_events, input window_rate,
                    input peak_rate, input average_rate, output ready);
endinterface

// ===== sv/sliding_window_event_rate_meter.sv =====
// Sliding window event rate meter: one result request for every tick request.
// On acceptance a tick updates the statistics; the serial divider is then
// loaded and produces the average one quotient bit per step, and the output
// register loads it once it is free. The 40-step divider sets the rate; a
// new tick is taken once the divider has handed over, even if the last result
// still waits in the output register. The window is a chain of SLOTS cells that
// shift once per tick, so the cell at the tail holds the count leaving the
// window. Depends on swerm_pkg, the two channel interfaces, swerm_slot_cell,
// swerm_div and the assertion macro header.
`include "sliding_window_event_rate_meter_defines.svh"

module sliding_window_event_rate_meter #(
    parameter int SLOTS = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    swerm_tick_if.sink     tick,
    swerm_result_if.source result
);

    localparam int CNT_W = swerm_pkg::CNT_W;
    localparam int WIN_W = swerm_pkg::WIN_W;
    localparam int TOT_W = swerm_pkg::TOT_W;
    localparam int ACT_W = swerm_pkg::ACT_W;
    localparam int AVG_W = swerm_pkg::AVG_W;
    localparam int POS_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_RUN,
        S_WAIT
    } state_t;

    state_t state_reg;

    // statistics
    logic [WIN_W-1:0] window_sum_reg;
    logic [TOT_W-1:0] total_reg;
    logic [WIN_W-1:0] peak_reg;
    logic [POS_W-1:0] pos_reg;
    logic [ACT_W-1:0] active_reg;

    // output register
    logic             out_valid_reg;
    logic [TOT_W-1:0] out_total_reg;
    logic [WIN_W-1:0] out_win_reg;
    logic [WIN_W-1:0] out_peak_reg;
    logic [AVG_W-1:0] out_avg_reg;

    logic                 accept;
    logic [CNT_W-1:0]     cnt;
    swerm_pkg::cell_ctl_t cell_ctl;
    logic [CNT_W-1:0]     slot_q [SLOTS];
    logic [CNT_W-1:0]     oldest;

    logic [TOT_W:0]   tot_sum;
    logic [TOT_W-1:0] total_next;
    logic [WIN_W-1:0] win_next;
    logic             wrap;

    swerm_pkg::div_stat_t div_stat;
    logic [AVG_W-1:0]     quotient;
    logic                 slot_free;
    logic                 load;

    // ---------------- input side ----------------
    assign tick.ready = (state_reg == S_IDLE);
    assign accept     = tick.valid && tick.ready;
    assign cnt        = tick.clear ? '0 : tick.event_count;   // clear tick counts as zero

    // ---------------- slot chain ----------------
    // cell 0 takes the new count, the tail cell holds the count aging out
    assign cell_ctl.shift = accept;
    assign cell_ctl.clear = accept && tick.clear;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        logic [CNT_W-1:0] d;
        if (i == 0)
        begin : g_head
            assign d = cnt;
        end
        else
        begin : g_link
            assign d = slot_q[i-1];
        end
        swerm_slot_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (cell_ctl),
            .d     (d),
            .q     (slot_q[i])
        );
    end

    assign oldest = slot_q[SLOTS-1];

    // ---------------- statistics update ----------------
    assign tot_sum    = {1'b0, total_reg} + (TOT_W+1)'(cnt);
    assign total_next = tot_sum[TOT_W] ? swerm_pkg::TOT_MAX : tot_sum[TOT_W-1:0];
    assign win_next   = window_sum_reg - WIN_W'(oldest) + WIN_W'(cnt);
    assign wrap       = (pos_reg == POS_W'(SLOTS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_sum_reg <= '0;
            total_reg      <= '0;
            peak_reg       <= '0;
            pos_reg        <= '0;
            active_reg     <= swerm_pkg::ACT_ONE;
        end
        else if (accept)
        begin
            priority if (tick.clear)
            begin
                // everything back to reset, then a zero-event tick
                window_sum_reg <= '0;
                total_reg      <= '0;
                peak_reg       <= '0;
                pos_reg        <= POS_W'(1);
                active_reg     <= swerm_pkg::ACT_ONE;
            end
            else
            begin
                window_sum_reg <= win_next;
                total_reg      <= total_next;
                if (win_next > peak_reg)
                begin
                    peak_reg <= win_next;
                end
                if (wrap)
                begin
                    pos_reg <= '0;
                    // a second counts only if its window saw events
                    if (win_next != '0 && active_reg != swerm_pkg::ACT_MAX)
                    begin
                        active_reg <= active_reg + ACT_W'(1);
                    end
                end
                else
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
        end
    end

    // ---------------- average: (total << 8) / active seconds ----------------
    swerm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_START),
        .dividend ({total_reg, {swerm_pkg::FRAC_W{1'b0}}}),
        .divisor  (active_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // ---------------- sequencer and output register ----------------
    assign slot_free = !out_valid_reg || result.ready;
    assign load      = slot_free &&
                       ((state_reg == S_RUN && div_stat.done) || state_reg == S_WAIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_total_reg <= '0;
            out_win_reg   <= '0;
            out_peak_reg  <= '0;
            out_avg_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_START;
                    end
                end
                S_START:
                begin
                    state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= slot_free ? S_IDLE : S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (load)
            begin
                out_valid_reg <= 1'b1;
                out_total_reg <= total_reg;
                out_win_reg   <= window_sum_reg;
                out_peak_reg  <= peak_reg;
                out_avg_reg   <= quotient;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.total_events = out_total_reg;
    assign result.window_rate  = out_win_reg;
    assign result.peak_rate    = out_peak_reg;
    assign result.average_rate = out_avg_reg;

    // ---------------- checks ----------------
    `SWERM_ASSERT(a_accept_starts_div, clk, rst_n, accept |=> state_reg == S_START)
    `SWERM_ASSERT(a_done_only_in_run, clk, rst_n, div_stat.done |-> state_reg == S_RUN)
    `SWERM_ASSERT(a_peak_covers_window, clk, rst_n, window_sum_reg <= peak_reg)
    `SWERM_ASSERT_ALWAYS(a_active_nonzero, clk, !rst_n || active_reg != '0)

endmodule

// ===== sv/swerm_slot_cell.sv =====
// One cell of the slot chain: holds one per-tick count, passes it on.
// Depends on swerm_pkg.
module swerm_slot_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  swerm_pkg::cell_ctl_t         ctl,
    input  logic [swerm_pkg::CNT_W-1:0]  d,
    output logic [swerm_pkg::CNT_W-1:0]  q
);

    logic [swerm_pkg::CNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.clear)
        begin
            count_reg <= '0;
        end
        else if (ctl.shift)
        begin
            count_reg <= d;
        end
    end

    assign q = count_reg;

endmodule

// ===== sv/swerm_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on swerm_pkg. Divisor must be nonzero.
module swerm_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [swerm_pkg::AVG_W-1:0]  dividend,
    input  logic [swerm_pkg::ACT_W-1:0]  divisor,
    output swerm_pkg::div_stat_t         stat,
    output logic [swerm_pkg::AVG_W-1:0]  quotient
);

    localparam int STEPS = swerm_pkg::AVG_W;
    localparam int CNT_W = $clog2(STEPS);
    localparam int DW    = swerm_pkg::ACT_W;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] step_reg;
    logic [STEPS-1:0] dvd_reg;     // dividend bits out, quotient bits in
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    dsr_reg;

    logic [DW:0]      rem_sh;
    logic [DW+1:0]    diff;
    logic             ge;

    assign rem_sh = {rem_reg, dvd_reg[STEPS-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dsr_reg};
    assign ge     = !diff[DW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            dvd_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                dvd_reg  <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
                dvd_reg <= {dvd_reg[STEPS-2:0], ge};
                if (step_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + CNT_W'(1);
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dvd_reg;

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for sliding_window_event_rate_meter: tick requests in, result requests out.
// Depends on swerm_pkg, swerm_tick_if, swerm_result_if and the meter RTL.
// An in-bench copy of the meter's arithmetic predicts each result.
module testbench;

    localparam int CNT_W  = swerm_pkg::CNT_W;
    localparam int WIN_W  = swerm_pkg::WIN_W;
    localparam int TOT_W  = swerm_pkg::TOT_W;
    localparam int ACT_W  = swerm_pkg::ACT_W;
    localparam int AVG_W  = swerm_pkg::AVG_W;
    localparam int FRAC_W = swerm_pkg::FRAC_W;

    localparam int WINDOW_SLOTS = 10;
    localparam int PHASE_TICKS  = 350;      // four random phases, about 1400 ticks
    localparam int DRAIN_CYCLES = 60;       // idle watch after the last result comes back

    // one pending tick request
    typedef struct {
        bit [CNT_W-1:0] cnt;
        bit             clr;
    } tick_req_t;

    // one predicted result request
    typedef struct {
        bit [TOT_W-1:0] total;
        bit [WIN_W-1:0] window;
        bit [WIN_W-1:0] peak;
        bit [AVG_W-1:0] average;
    } meter_result_t;

    // shape of a random run of ticks
    typedef enum {
        SEG_RANDOM,
        SEG_QUIET,
        SEG_BURST,
        SEG_LOW
    } seg_kind_t;

    logic clk;
    logic rst_n;

    swerm_tick_if   tick_ch ();
    swerm_result_if result_ch ();

    sliding_window_event_rate_meter #(
        .SLOTS (WINDOW_SLOTS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (result_ch)
    );

    // ---------------------------------------------------------------
    // Meter state as the bench sees it. Starts at reset values; rst_n
    // is pulsed only once, so no second reset path is needed here.
    // ---------------------------------------------------------------
    bit [CNT_W-1:0] slot_hist [WINDOW_SLOTS];
    bit [WIN_W-1:0] win_sum  = '0;
    bit [TOT_W-1:0] tot_sum  = '0;
    bit [WIN_W-1:0] peak_win = '0;
    int unsigned    slot_idx = 0;
    bit [ACT_W-1:0] act_secs = swerm_pkg::ACT_ONE;

    tick_req_t     tick_pending [$];    // ticks not yet offered to the meter
    meter_result_t rate_expected [$];   // predicted results, oldest first

    tick_req_t tick_next;
    bit        tick_taken = 1'b0;
    bit        failed     = 1'b0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;

    // Apply one accepted tick to the bench state and return the result
    // the meter must produce for it.
    function automatic meter_result_t meter_advance(input bit [CNT_W-1:0] cnt_in,
                                                    input bit clr);
        meter_result_t  r;
        bit [CNT_W-1:0] cnt;
        bit [63:0]      num;
        cnt = cnt_in;
        // clear wipes everything and the tick itself counts as no events
        if (clr)
        begin
            foreach (slot_hist[i])
                slot_hist[i] = '0;
            win_sum  = '0;
            tot_sum  = '0;
            peak_win = '0;
            slot_idx = 0;
            act_secs = swerm_pkg::ACT_ONE;
            cnt      = '0;
        end
        // saturating running total
        if (tot_sum > swerm_pkg::TOT_MAX - TOT_W'(cnt))
            tot_sum = swerm_pkg::TOT_MAX;
        else
            tot_sum = tot_sum + TOT_W'(cnt);
        // oldest count leaves the window, new one enters
        win_sum = win_sum - WIN_W'(slot_hist[slot_idx]) + WIN_W'(cnt);
        slot_hist[slot_idx] = cnt;
        if (win_sum > peak_win)
            peak_win = win_sum;
        // a full lap of the ring is one second; it counts only if the window is busy
        slot_idx++;
        if (slot_idx >= WINDOW_SLOTS)
        begin
            slot_idx = 0;
            if (win_sum != '0 && act_secs != swerm_pkg::ACT_MAX)
                act_secs = act_secs + 1'b1;
        end
        num       = 64'(tot_sum) << FRAC_W;
        r.total   = tot_sum;
        r.window  = win_sum;
        r.peak    = peak_win;
        r.average = AVG_W'(num / 64'(act_secs));
        return r;
    endfunction

    // Queue n random ticks, built from runs of similar counts. Quiet runs
    // longer than the window make the ring lap with an empty window; bursts
    // push the window toward its top. Clears land now and then.
    task automatic queue_random_ticks(input int n);
        seg_kind_t kind;
        int        run_len;
        tick_req_t t;
        while (n > 0)
        begin
            kind    = seg_kind_t'($urandom_range(3));
            run_len = $urandom_range(25, 3);
            for (int k = 0; k < run_len && n > 0; k++)
            begin
                case (kind)
                    SEG_RANDOM: t.cnt = CNT_W'($urandom_range(255));
                    SEG_QUIET:  t.cnt = '0;
                    SEG_BURST:  t.cnt = CNT_W'($urandom_range(255, 240));
                    default:    t.cnt = CNT_W'($urandom_range(3));
                endcase
                t.clr = ($urandom_range(59) == 0);
                // a clear still carries a count, which must be ignored
                if (t.clr)
                    t.cnt = CNT_W'($urandom_range(255));
                tick_pending.push_back(t);
                n--;
            end
        end
    endtask

    task automatic wait_sent;
        while (tick_pending.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Clock and reset
    // ---------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Driver: inputs move on the falling edge. A tick request stays up
    // until taken; a new one goes out only after the old one was taken
    // at the last rising edge.
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            tick_ch.valid  <= 1'b0;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (!tick_ch.valid || tick_taken)
            begin
                if (tick_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    tick_next = tick_pending.pop_front();
                    tick_ch.valid       <= 1'b1;
                    tick_ch.event_count <= tick_next.cnt;
                    tick_ch.clear       <= tick_next.clr;
                end
                else
                    tick_ch.valid <= 1'b0;
            end
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // Monitor: both handshakes are sampled on the rising edge. The tick
    // is predicted first so a result in the same edge sees the queue as
    // it stood.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        meter_result_t want;
        if (!rst_n)
            tick_taken = 1'b0;
        else
        begin
            tick_taken = tick_ch.valid && tick_ch.ready;
            if (tick_taken)
                rate_expected.push_back(meter_advance(tick_ch.event_count, tick_ch.clear));
            if (result_ch.valid && result_ch.ready)
            begin
                if (rate_expected.size() == 0)
                begin
                    $error("result request with no tick waiting for it");
                    failed = 1'b1;
                end
                else
                begin
                    want = rate_expected.pop_front();
                    if (result_ch.total_events !== want.total)
                    begin
                        $error("total_events expected %0d got %0d",
                               want.total, result_ch.total_events);
                        failed = 1'b1;
                    end
                    if (result_ch.window_rate !== want.window)
                    begin
                        $error("window_rate expected %0d got %0d",
                               want.window, result_ch.window_rate);
                        failed = 1'b1;
                    end
                    if (result_ch.peak_rate !== want.peak)
                    begin
                        $error("peak_rate expected %0d got %0d",
                               want.peak, result_ch.peak_rate);
                        failed = 1'b1;
                    end
                    if (result_ch.average_rate !== want.average)
                    begin
                        $error("average_rate expected %0d got %0d",
                               want.average, result_ch.average_rate);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus and phase control
    // ---------------------------------------------------------------
    initial
    begin
        tick_ch.valid       = 1'b0;
        tick_ch.event_count = '0;
        tick_ch.clear       = 1'b0;
        result_ch.ready     = 1'b0;
        rst_n               = 1'b0;

        // Directed: a clear whose count must be dropped, a full window of
        // maximum counts (peak at the top, first second counted), a full
        // window of zeros (a lap with one maximum count left adds a second,
        // then it empties), then small and mid counts and a clear in mid-ring.
        tick_pending.push_back('{cnt: 8'hAA, clr: 1'b1});
        repeat (WINDOW_SLOTS)
            tick_pending.push_back('{cnt: 8'hFF, clr: 1'b0});
        repeat (WINDOW_SLOTS)
            tick_pending.push_back('{cnt: 8'h00, clr: 1'b0});
        tick_pending.push_back('{cnt: 8'h01, clr: 1'b0});
        tick_pending.push_back('{cnt: 8'h80, clr: 1'b0});
        tick_pending.push_back('{cnt: 8'hFF, clr: 1'b1});
        tick_pending.push_back('{cnt: 8'h7F, clr: 1'b0});

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // phase 1: both sides flat out
        queue_random_ticks(PHASE_TICKS);
        wait_sent();
        // phase 2: sender mostly idle
        send_idle_pct  = 86;
        recv_stall_pct = 0;
        queue_random_ticks(PHASE_TICKS);
        wait_sent();
        // phase 3: receiver mostly stalled
        send_idle_pct  = 0;
        recv_stall_pct = 86;
        queue_random_ticks(PHASE_TICKS);
        wait_sent();
        // phase 4: light gaps on both sides
        send_idle_pct  = 13;
        recv_stall_pct = 13;
        queue_random_ticks(PHASE_TICKS);
        wait_sent();

        // let the last tick get taken and every result come back
        while (tick_ch.valid || rate_expected.size() != 0)
            @(posedge clk);
        // watch a little longer for stray results
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (!failed)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: ends a hung run of the ~1425 ticks.
    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/swerm_pkg.sv
sv/swerm_tick_if.sv
sv/swerm_result_if.sv
sv/swerm_slot_cell.sv
sv/swerm_div.sv
sv/sliding_window_event_rate_meter.sv
test/testbench.sv
